/* rtl/pcbd_pkg.sv */
// Shared types and constants for the prefix-code bit decoder.
// No dependencies; imported by pcbd_match and the top level.
package pcbd_pkg;

    localparam int OP_W     = 2;
    localparam int IDX_IN_W = 8;
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int SYM_W    = 8;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BIT   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
        logic [SYM_W-1:0]  symbol;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* rtl/pcbd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcbd_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pcbd_match.sv */
// Compare unit: checks one table entry against the bit accumulator.
// Depends on pcbd_pkg (t_entry).
module pcbd_match #(
    parameter int ACC_W  = 16,
    parameter int ALEN_W = 5
) (
    input  logic               i_slot_valid,
    input  pcbd_pkg::t_entry   i_entry,
    input  logic [ACC_W-1:0]   i_acc,
    input  logic [ALEN_W-1:0]  i_acc_len,
    output logic               o_hit
);

    import pcbd_pkg::*;

    logic [ACC_W-1:0] code_ext;
    logic [ACC_W-1:0] len_mask;
    logic             len_eq;

    assign code_ext = ACC_W'(i_entry.code);

    always_comb begin
        for (int j = 0; j < ACC_W; j++) begin
            len_mask[j] = (j < 32'(i_acc_len));
        end
    end

    assign len_eq = (32'(i_entry.length) == 32'(i_acc_len));
    assign o_hit  = i_slot_valid && len_eq && ((code_ext & len_mask) == i_acc);

endmodule

/* rtl/prefix_code_bit_decoder_unit.sv */
// Prefix-code decoder top level: sequencer, valid bits, accumulator, result register.
// Depends on pcbd_pkg, pcbd_ram and pcbd_match.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------------------
//  input   | in        | i_valid / o_stall | i_opcode, i_entry_*, i_code_bit
//  output  | out       | o_valid / i_stall | o_symbol_valid, o_symbol, o_code_error,
//          |           |                   | o_pending_length
//
// Load, clear and unused opcodes go straight from idle to the result state.
// A decode bit scans the table memory's single read port one entry per cycle;
// the scan ends at the first match or after the last entry.
// Reset clears the valid bits and the accumulator at once; no clearing pass.
// A stalled result holds in the output register; the next item is taken meanwhile.
module prefix_code_bit_decoder_unit #(
    parameter int NUM_ENTRIES  = 256,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [pcbd_pkg::OP_W-1:0]     i_opcode,
    input  logic [pcbd_pkg::IDX_IN_W-1:0] i_entry_index,
    input  logic [pcbd_pkg::CODE_W-1:0]   i_entry_code,
    input  logic [pcbd_pkg::LEN_W-1:0]    i_entry_length,
    input  logic [pcbd_pkg::SYM_W-1:0]    i_entry_symbol,
    input  logic                      i_code_bit,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_symbol_valid,
    output logic [pcbd_pkg::SYM_W-1:0]    o_symbol,
    output logic                      o_code_error,
    output logic [pcbd_pkg::LEN_W-1:0]    o_pending_length
);

    import pcbd_pkg::*;

    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int ACC_W  = MAX_CODE_LEN;
    localparam int ALEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0]             r_state;
    logic [NUM_ENTRIES-1:0] r_slot_valid;
    logic [ACC_W-1:0]       r_acc;
    logic [ALEN_W-1:0]      r_acc_len;
    logic [IDX_W-1:0]       r_addr;
    logic                   r_issue;
    logic                   r_chk;
    logic [IDX_W-1:0]       r_chk_idx;

    logic                   r_res_sym_vld;
    logic [SYM_W-1:0]       r_res_sym;
    logic                   r_res_err;
    logic [LEN_W-1:0]       r_res_pend;

    logic                   r_out_valid;
    logic                   r_out_sym_vld;
    logic [SYM_W-1:0]       r_out_sym;
    logic                   r_out_err;
    logic [LEN_W-1:0]       r_out_pend;

    logic                   in_xfer;
    logic                   load_we;
    logic [IDX_W-1:0]       load_idx;
    t_entry                 load_entry;
    t_entry                 rd_entry;
    logic [ENTRY_W-1:0]     rd_data;
    logic                   hit;
    logic [ACC_W-1:0]       n_acc;
    logic [ALEN_W-1:0]      n_acc_len;
    logic                   out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign load_idx   = i_entry_index[IDX_W-1:0];
    assign load_we    = in_xfer && (i_opcode == OP_LOAD) &&
                        (32'(i_entry_index) < NUM_ENTRIES);
    assign load_entry = '{code: i_entry_code, length: i_entry_length, symbol: i_entry_symbol};

    assign n_acc     = ACC_W'({r_acc, i_code_bit});
    assign n_acc_len = r_acc_len + ALEN_W'(1);

    pcbd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_idx),
        .i_wdata (load_entry),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    assign rd_entry = t_entry'(rd_data);

    pcbd_match #(
        .ACC_W  (ACC_W),
        .ALEN_W (ALEN_W)
    ) u_match (
        .i_slot_valid (r_slot_valid[r_chk_idx]),
        .i_entry      (rd_entry),
        .i_acc        (r_acc),
        .i_acc_len    (r_acc_len),
        .o_hit        (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_acc        <= '0;
            r_acc_len    <= '0;
            r_addr       <= '0;
            r_issue      <= 1'b0;
            r_chk        <= 1'b0;
            r_chk_idx    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_res_sym_vld <= 1'b0;
                        r_res_sym     <= '0;
                        r_res_err     <= 1'b0;
                        r_res_pend    <= LEN_W'(r_acc_len);
                        r_state       <= S_RES;
                        if (load_we) begin
                            r_slot_valid[load_idx] <= (i_entry_length != '0);
                        end
                        if (i_opcode == OP_CLEAR) begin
                            r_slot_valid <= '0;
                            r_acc        <= '0;
                            r_acc_len    <= '0;
                            r_res_pend   <= '0;
                        end
                        if (i_opcode == OP_BIT) begin
                            r_acc     <= n_acc;
                            r_acc_len <= n_acc_len;
                            r_addr    <= '0;
                            r_issue   <= 1'b1;
                            r_chk     <= 1'b0;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_chk     <= r_issue;
                    r_chk_idx <= r_addr;
                    if (r_addr == LAST_IDX) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_addr <= r_addr + IDX_W'(1);
                    end
                    if (r_chk && (hit || r_chk_idx == LAST_IDX)) begin
                        r_chk   <= 1'b0;
                        r_issue <= 1'b0;
                        r_state <= S_RES;
                        if (hit) begin
                            r_res_sym_vld <= 1'b1;
                            r_res_sym     <= rd_entry.symbol;
                            r_res_err     <= 1'b0;
                            r_res_pend    <= '0;
                            r_acc         <= '0;
                            r_acc_len     <= '0;
                        end else if (32'(r_acc_len) >= MAX_CODE_LEN) begin
                            r_res_sym_vld <= 1'b0;
                            r_res_sym     <= '0;
                            r_res_err     <= 1'b1;
                            r_res_pend    <= '0;
                            r_acc         <= '0;
                            r_acc_len     <= '0;
                        end else begin
                            r_res_sym_vld <= 1'b0;
                            r_res_sym     <= '0;
                            r_res_err     <= 1'b0;
                            r_res_pend    <= LEN_W'(r_acc_len);
                        end
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RES && out_free) begin
            r_out_sym_vld <= r_res_sym_vld;
            r_out_sym     <= r_res_sym;
            r_out_err     <= r_res_err;
            r_out_pend    <= r_res_pend;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_symbol_valid   = r_out_sym_vld;
    assign o_symbol         = r_out_sym;
    assign o_code_error     = r_out_err;
    assign o_pending_length = r_out_pend;

    a_acc_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> (32'(r_acc_len) < MAX_CODE_LEN))
        else $error("accumulator length reached the maximum");

    a_sym_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_symbol_valid && o_code_error))
        else $error("symbol and error flagged together");

    a_hit_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_symbol_valid || o_code_error)) |-> (o_pending_length == '0))
        else $error("accumulator not empty after completed code");

    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> (r_state == S_SCAN))
        else $error("compare pending outside scan");

    a_scan_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_chk && hit) |=> (r_state == S_RES && r_acc_len == '0))
        else $error("hit did not end scan");

endmodule

/* sim/tb_prefix_code_bit_decoder_unit.sv */
// Self-checking bench for prefix_code_bit_decoder_unit: table loads, clears and coded bit streams.
// Needs pcbd_pkg and the block's RTL; a scoreboard class predicts every result in order.
`timescale 1ns / 1ps

module tb_prefix_code_bit_decoder_unit;

    import pcbd_pkg::*;

    localparam int NUM_SLOTS   = 256;
    localparam int MAX_LEN     = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic             sym_valid;
        logic [SYM_W-1:0] symbol;
        logic             code_err;
        logic [LEN_W-1:0] pend_len;
    } t_decode_result;

    class decode_tracker;
        bit               slot_valid [NUM_SLOTS];
        logic [CODE_W-1:0] slot_code [NUM_SLOTS];
        logic [LEN_W-1:0]  slot_len  [NUM_SLOTS];
        logic [SYM_W-1:0]  slot_sym  [NUM_SLOTS];
        logic [CODE_W-1:0] acc_bits;
        logic [LEN_W-1:0]  acc_len;
        t_decode_result    due_results [$];
        int                errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_valid[i] = 1'b0;
                slot_code[i]  = '0;
                slot_len[i]   = '0;
                slot_sym[i]   = '0;
            end
            acc_bits = '0;
            acc_len  = '0;
            errors   = 0;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function void predict_item(input logic [OP_W-1:0] op, input logic [IDX_IN_W-1:0] idx,
                                   input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                                   input logic [SYM_W-1:0] sym, input logic b);
            t_decode_result r;
            logic [CODE_W:0] mask;
            r = '0;
            case (op)
                OP_LOAD: begin
                    slot_valid[idx] = (len != '0);
                    slot_code[idx]  = code;
                    slot_len[idx]   = len;
                    slot_sym[idx]   = sym;
                end
                OP_CLEAR: begin
                    for (int i = 0; i < NUM_SLOTS; i++) slot_valid[i] = 1'b0;
                    acc_bits = '0;
                    acc_len  = '0;
                end
                OP_BIT: begin
                    acc_bits = {acc_bits[CODE_W-2:0], b};
                    acc_len  = acc_len + 1'b1;
                    mask     = (17'd1 << acc_len) - 17'd1;
                    for (int i = 0; i < NUM_SLOTS && !r.sym_valid; i++) begin
                        if (slot_valid[i] && slot_len[i] == acc_len &&
                            (slot_code[i] & mask[CODE_W-1:0]) == acc_bits) begin
                            r.sym_valid = 1'b1;
                            r.symbol    = slot_sym[i];
                        end
                    end
                    if (r.sym_valid || acc_len >= MAX_LEN) begin
                        r.code_err = !r.sym_valid;
                        acc_bits   = '0;
                        acc_len    = '0;
                    end
                end
                default: ;
            endcase
            r.pend_len = acc_len;
            due_results.push_back(r);
        endfunction

        function void compare_result(input t_decode_result got);
            t_decode_result want;
            if (due_results.size() == 0) begin
                $error("result with no pending transfer: %h", got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.sym_valid !== want.sym_valid) begin
                $error("symbol_valid: expected %0d, actual %0d", want.sym_valid, got.sym_valid);
                errors++;
            end
            if (got.symbol !== want.symbol) begin
                $error("symbol: expected %0h, actual %0h", want.symbol, got.symbol);
                errors++;
            end
            if (got.code_err !== want.code_err) begin
                $error("code_error: expected %0d, actual %0d", want.code_err, got.code_err);
                errors++;
            end
            if (got.pend_len !== want.pend_len) begin
                $error("pending_length: expected %0d, actual %0d", want.pend_len, got.pend_len);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [OP_W-1:0]     i_opcode;
    logic [IDX_IN_W-1:0] i_entry_index;
    logic [CODE_W-1:0]   i_entry_code;
    logic [LEN_W-1:0]    i_entry_length;
    logic [SYM_W-1:0]    i_entry_symbol;
    logic                i_code_bit;
    logic                o_valid;
    logic                i_stall;
    logic                o_symbol_valid;
    logic [SYM_W-1:0]    o_symbol;
    logic                o_code_error;
    logic [LEN_W-1:0]    o_pending_length;

    decode_tracker tracker;
    int  tx_idle_pct;
    int  rx_idle_pct;
    int  items_sent;
    int  cycle_count;
    int  hold_left;
    bit  hold_req;

    prefix_code_bit_decoder_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_entry_index    (i_entry_index),
        .i_entry_code     (i_entry_code),
        .i_entry_length   (i_entry_length),
        .i_entry_symbol   (i_entry_symbol),
        .i_code_bit       (i_code_bit),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_symbol_valid   (o_symbol_valid),
        .o_symbol         (o_symbol),
        .o_code_error     (o_code_error),
        .o_pending_length (o_pending_length)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_decode_result got;
        hold_left = 0;
        i_stall   <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                got = '{o_symbol_valid, o_symbol, o_code_error, o_pending_length};
                tracker.compare_result(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_IN_W-1:0] idx,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                             input logic [SYM_W-1:0] sym, input logic b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_entry_index  <= idx;
        i_entry_code   <= code;
        i_entry_length <= len;
        i_entry_symbol <= sym;
        i_code_bit     <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.predict_item(op, idx, code, len, sym, b);
        if (op != OP_UNUSED) items_sent++;
    endtask

    task automatic send_load(input logic [IDX_IN_W-1:0] idx, input logic [CODE_W-1:0] code,
                             input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym);
        send_item(OP_LOAD, idx, code, len, sym, 1'($urandom_range(1)));
    endtask

    task automatic send_bit(input logic b);
        send_item(OP_BIT, 8'($urandom), 16'($urandom), 5'($urandom), 8'($urandom), b);
    endtask

    task automatic send_clear();
        send_item(OP_CLEAR, 8'($urandom), 16'($urandom), 5'($urandom), 8'($urandom),
                  1'($urandom_range(1)));
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int n_items);
        int start, k, w, pick;
        bit drop_top, invert, wide, hold_done;
        logic [CODE_W-1:0] cw_code [17];
        int cw_len [17];
        logic [CODE_W-1:0] mask;
        start     = items_sent;
        hold_done = 1'b0;
        while (items_sent - start < n_items) begin
            if (!hold_done && items_sent - start >= n_items / 2) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_item(2'($urandom_range(3)), 8'($urandom), 16'($urandom), 5'($urandom),
                          8'($urandom), 1'($urandom_range(1)));
            end else if (pick < 10) begin
                w = $urandom_range(1);
                repeat ($urandom_range(16, 20)) send_bit(w ? 1'b1 : 1'($urandom_range(1)));
            end else begin
                if ($urandom_range(2) != 0) send_clear();
                k        = ($urandom_range(7) == 0) ? $urandom_range(2, 17) : $urandom_range(2, 6);
                drop_top = ($urandom_range(2) == 0);
                invert   = 1'($urandom_range(1));
                wide     = ($urandom_range(3) == 0);
                for (int j = 0; j < k; j++) begin
                    cw_len[j]  = (j < k - 1) ? j + 1 : k - 1;
                    mask       = 16'((17'd1 << cw_len[j]) - 17'd1);
                    cw_code[j] = (j < k - 1) ? 16'(((1 << j) - 1) << 1) : mask;
                    if (invert) cw_code[j] = cw_code[j] ^ mask;
                    if (!(drop_top && j == k - 1))
                        send_load(wide ? 8'($urandom_range(255)) : 8'($urandom_range(15)),
                                  cw_code[j] | (16'($urandom) & ~mask), 5'(cw_len[j]),
                                  8'($urandom));
                end
                if ($urandom_range(3) == 0)
                    send_load(8'($urandom), 16'($urandom),
                              $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31)),
                              8'($urandom));
                repeat ($urandom_range(3, 16)) begin
                    if ($urandom_range(11) == 0) begin
                        send_bit(1'($urandom_range(1)));
                    end else begin
                        w = $urandom_range(drop_top ? k - 2 : k - 1);
                        for (int b = cw_len[w] - 1; b >= 0; b--) send_bit(cw_code[w][b]);
                    end
                end
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_opcode       <= OP_LOAD;
        i_entry_index  <= '0;
        i_entry_code   <= '0;
        i_entry_length <= '0;
        i_entry_symbol <= '0;
        i_code_bit     <= 1'b0;
        tracker     = new();
        tx_idle_pct = 38;
        rx_idle_pct = 70;
        items_sent  = 0;
        cycle_count = 0;
        hold_req    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_load(8'd10, 16'hFFF2, 5'd2, 8'hA5);
        send_load(8'd5, 16'h0002, 5'd2, 8'h3C);
        send_load(8'd255, 16'hFFFF, 5'd16, 8'hFF);
        send_load(8'd20, 16'h0000, 5'd31, 8'h77);
        send_item(OP_UNUSED, 8'($urandom), 16'($urandom), 5'($urandom), 8'($urandom), 1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        send_load(8'd5, 16'h0002, 5'd0, 8'h00);
        send_bit(1'b1);
        send_bit(1'b0);
        repeat (MAX_LEN) send_bit(1'b1);
        send_bit(1'b1);
        send_clear();

        run_random(215);
        tx_idle_pct = 70;
        rx_idle_pct = 38;
        wait_for_drain();
        run_random(215);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_for_drain();
        run_random(215);

        wait_for_drain();
        repeat (NUM_SLOTS + 8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
